### rtl/scpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_pkg
// shared types and constants of the set-associative fifo cache with prefetch
// ----------------------------------------------------------------------------
package scpf_pkg;

    localparam int ADDR_BITS = 48;
    localparam int CNT_W     = 32;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_SET_COUNT_LOG2  = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE_LOG2 = 2'd1;
    localparam logic [1:0] REG_WAYS_IN_USE     = 2'd2;
    localparam logic [1:0] REG_PREFETCH_ENABLE = 2'd3;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [3:0] set_count_log2;
        logic [3:0] block_size_log2;
        logic [3:0] ways_in_use;
        logic       prefetch_enable;
    } t_cfg;

    typedef struct packed {
        logic                 opcode;
        logic [ADDR_BITS-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic [1:0]       reads_caused;
        logic             write_caused;
        logic [CNT_W-1:0] total_hits;
        logic [CNT_W-1:0] total_misses;
        logic [CNT_W-1:0] total_reads;
        logic [CNT_W-1:0] total_writes;
    } t_out_item;

endpackage
`default_nettype wire

### rtl/set_assoc_cache_fifo_prefetch_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_prefetch_core
// write-through set-associative cache model with fifo replacement and
// next-block prefetch, reporting per-access traffic and running counters
// ----------------------------------------------------------------------------
//  port group   direction  handshake                     payload
//  in item      in         i_in_valid / o_in_stall       i_in_data   (t_in_item)
//  result       out        o_out_valid / i_out_stall     o_out_data  (t_out_item)
//  config       in         psel, penable, pwrite, pready paddr, pwdata / prdata
//
//  one lookup shifts the address to a block, splits it into set and tag, then reads
//  and compares one way at a time, with a fill step on a miss; the shared tag
//  comparator checks one way per step; an access costs one lookup, or two on a miss
//  with prefetch; the next access is taken while the result waits in its register
//  after reset the tag store is cleared entry by entry, with o_in_stall high
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_prefetch_core #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire scpf_pkg::t_in_item             i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output scpf_pkg::t_out_item                 o_out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [scpf_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [scpf_pkg::PDATA_W-1:0]   pwdata,
    output logic      [scpf_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);
    import scpf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DEMAND, S_PREF, S_RESULT} t_state;

    t_state               r_state;
    logic                 r_is_write;
    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_hit;
    logic [1:0]           r_reads;
    logic [CNT_W-1:0]     r_hits, r_misses, r_mem_reads, r_mem_writes;
    logic                 r_out_valid;
    t_out_item            r_out;

    t_cfg                 cfg;
    logic                 lk_ready, lk_done, lk_hit, lk_start;
    logic [ADDR_BITS-1:0] lk_addr;
    logic [ADDR_BITS-1:0] next_addr;
    logic                 in_xfer;
    logic                 out_free;
    logic [CNT_W-1:0]     hits_nx, misses_nx, reads_nx, writes_nx;

    scpf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    scpf_lookup #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_start (lk_start),
        .i_addr  (lk_addr),
        .o_ready (lk_ready),
        .o_done  (lk_done),
        .o_hit   (lk_hit)
    );

    assign o_in_stall = !((r_state == S_IDLE) && lk_ready);
    assign in_xfer    = i_in_valid && !o_in_stall;
    // next block wraps within the address width
    assign next_addr  = r_addr + (ADDR_BITS'(1) << cfg.block_size_log2);
    assign lk_start   = in_xfer ||
                        ((r_state == S_DEMAND) && lk_done && !lk_hit && cfg.prefetch_enable);
    assign lk_addr    = (r_state == S_IDLE) ? i_in_data.address : next_addr;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign hits_nx   = r_hits + CNT_W'(r_hit);
    assign misses_nx = r_misses + CNT_W'(!r_hit);
    assign reads_nx  = r_mem_reads + CNT_W'(r_reads);
    assign writes_nx = r_mem_writes + CNT_W'(r_is_write == OP_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hits       <= '0;
            r_misses     <= '0;
            r_mem_reads  <= '0;
            r_mem_writes <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_DEMAND;
                    end
                end
                S_DEMAND: begin
                    if (lk_done) begin
                        if (!lk_hit && cfg.prefetch_enable) begin
                            r_state <= S_PREF;
                        end else begin
                            r_state <= S_RESULT;
                        end
                    end
                end
                S_PREF: begin
                    if (lk_done) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_hits       <= hits_nx;
                        r_misses     <= misses_nx;
                        r_mem_reads  <= reads_nx;
                        r_mem_writes <= writes_nx;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if ((r_state == S_RESULT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_is_write <= i_in_data.opcode;
            r_addr     <= i_in_data.address;
        end
        if ((r_state == S_DEMAND) && lk_done) begin
            r_hit   <= lk_hit;
            r_reads <= lk_hit ? 2'd0 : 2'd1;
        end
        if ((r_state == S_PREF) && lk_done && !lk_hit) begin
            r_reads <= 2'd2;
        end
        if ((r_state == S_RESULT) && out_free) begin
            r_out.hit          <= r_hit;
            r_out.reads_caused <= r_reads;
            r_out.write_caused <= (r_is_write == OP_WRITE);
            r_out.total_hits   <= hits_nx;
            r_out.total_misses <= misses_nx;
            r_out.total_reads  <= reads_nx;
            r_out.total_writes <= writes_nx;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

### rtl/scpf_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_cfg
// apb register bank holding the cache geometry and prefetch enable
// ----------------------------------------------------------------------------
module scpf_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [scpf_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [scpf_pkg::PDATA_W-1:0]   pwdata,
    output logic      [scpf_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    output scpf_pkg::t_cfg                      o_cfg
);
    import scpf_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_count_log2  <= 4'd0;
            r_cfg.block_size_log2 <= 4'd4;
            r_cfg.ways_in_use     <= 4'd1;
            r_cfg.prefetch_enable <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SET_COUNT_LOG2:  r_cfg.set_count_log2  <= pwdata[3:0];
                REG_BLOCK_SIZE_LOG2: r_cfg.block_size_log2 <= pwdata[3:0];
                REG_WAYS_IN_USE:     r_cfg.ways_in_use     <= pwdata[3:0];
                REG_PREFETCH_ENABLE: r_cfg.prefetch_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SET_COUNT_LOG2:  prdata = PDATA_W'(r_cfg.set_count_log2);
            REG_BLOCK_SIZE_LOG2: prdata = PDATA_W'(r_cfg.block_size_log2);
            REG_WAYS_IN_USE:     prdata = PDATA_W'(r_cfg.ways_in_use);
            REG_PREFETCH_ENABLE: prdata = PDATA_W'(r_cfg.prefetch_enable);
            default:             prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/scpf_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_lookup
// look up one block address in its set, one way per step through a shared
// tag comparator, and fill it at the set's fifo pointer on a miss
// ----------------------------------------------------------------------------
module scpf_lookup #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire scpf_pkg::t_cfg                   i_cfg,
    input  wire logic                             i_start,
    input  wire logic [scpf_pkg::ADDR_BITS-1:0]   i_addr,
    output logic                                  o_ready,
    output logic                                  o_done,
    output logic                                  o_hit
);
    import scpf_pkg::*;

    localparam int DEPTH   = MAX_SETS * MAX_WAYS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SET_LOG = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WC_W    = $clog2(MAX_WAYS + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SHIFT, S_SPLIT, S_SCAN, S_COMP, S_FILL
    } t_state;

    t_state                r_state, n_state;
    logic [ADDR_BITS-1:0]  r_addr,  n_addr;
    logic [ADDR_BITS-1:0]  r_blk,   n_blk;
    logic [ADDR_BITS-1:0]  r_tag,   n_tag;
    logic [SET_W-1:0]      r_set,   n_set;
    logic [WAY_W-1:0]      r_way,   n_way;
    logic [AW-1:0]         r_clr,   n_clr;
    logic                  r_done,  n_done;
    logic                  r_hit,   n_hit;

    // tag store entries: valid bit on top of the tag
    logic [ADDR_BITS:0]    tag_mem [DEPTH];
    logic [ADDR_BITS:0]    r_rd_q;
    logic [WAY_W-1:0]      ptr_mem [MAX_SETS];
    logic [WAY_W-1:0]      r_ptr_q;

    logic [3:0]            slog_eff;
    logic [WC_W-1:0]       ways_eff;
    logic [SET_W-1:0]      set_mask;
    logic [AW-1:0]         base;
    logic [AW-1:0]         rd_addr;
    logic [WAY_W-1:0]      fill_way;
    logic [WC_W-1:0]       fill_next;
    logic [WAY_W-1:0]      ptr_new;
    logic                  tag_we;
    logic [AW-1:0]         tag_wa;
    logic [ADDR_BITS:0]    tag_wd;
    logic                  ptr_we;
    logic [SET_W-1:0]      ptr_wa;
    logic [WAY_W-1:0]      ptr_wd;
    logic                  match;
    logic                  last_way;

    always_comb begin
        slog_eff = (i_cfg.set_count_log2 > 4'(SET_LOG)) ? 4'(SET_LOG) : i_cfg.set_count_log2;
        if (i_cfg.ways_in_use == 4'd0) begin
            ways_eff = WC_W'(1);
        end else if (6'(i_cfg.ways_in_use) > 6'(MAX_WAYS)) begin
            ways_eff = WC_W'(MAX_WAYS);
        end else begin
            ways_eff = WC_W'(i_cfg.ways_in_use);
        end
    end

    assign set_mask = ~({SET_W{1'b1}} << slog_eff);
    assign base     = AW'(r_set) * AW'(MAX_WAYS);
    assign rd_addr  = base + AW'(r_way);
    assign match    = r_rd_q[ADDR_BITS] && (r_rd_q[ADDR_BITS-1:0] == r_tag);
    assign last_way = (WC_W'(r_way) + WC_W'(1)) >= ways_eff;

    // a pointer left past the ways in use after reconfiguration falls back to way 0
    assign fill_way  = (WC_W'(r_ptr_q) >= ways_eff) ? '0 : r_ptr_q;
    assign fill_next = WC_W'(fill_way) + WC_W'(1);
    assign ptr_new   = (fill_next >= ways_eff) ? '0 : WAY_W'(fill_next);

    always_comb begin
        tag_we = (r_state == S_CLEAR) || (r_state == S_FILL);
        tag_wa = (r_state == S_CLEAR) ? r_clr : base + AW'(fill_way);
        tag_wd = (r_state == S_CLEAR) ? '0 : {1'b1, r_tag};
        ptr_we = ((r_state == S_CLEAR) && (32'(r_clr) < 32'(MAX_SETS))) ||
                 (r_state == S_FILL);
        ptr_wa = (r_state == S_CLEAR) ? r_clr[SET_W-1:0] : r_set;
        ptr_wd = (r_state == S_CLEAR) ? '0 : ptr_new;
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            tag_mem[tag_wa] <= tag_wd;
        end
        r_rd_q <= tag_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ptr_we) begin
            ptr_mem[ptr_wa] <= ptr_wd;
        end
        r_ptr_q <= ptr_mem[r_set];
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_blk   = r_blk;
        n_tag   = r_tag;
        n_set   = r_set;
        n_way   = r_way;
        n_clr   = r_clr;
        n_done  = 1'b0;
        n_hit   = r_hit;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_addr  = i_addr;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_blk   = r_addr >> i_cfg.block_size_log2;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                n_set   = r_blk[SET_W-1:0] & set_mask;
                n_tag   = r_blk >> slog_eff;
                n_way   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_state = S_COMP;
            end
            S_COMP: begin
                if (match) begin
                    n_hit   = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (last_way) begin
                    n_state = S_FILL;
                end else begin
                    n_way   = r_way + WAY_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_FILL: begin
                n_hit   = 1'b0;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
            r_hit   <= n_hit;
        end
        r_addr <= n_addr;
        r_blk  <= n_blk;
        r_tag  <= n_tag;
        r_set  <= n_set;
        r_way  <= n_way;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = r_done;
    assign o_hit   = r_hit;

endmodule
`default_nettype wire

### sim/set_assoc_cache_fifo_prefetch_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_prefetch_core_tb
// drives cache accesses through the valid/stall input channel, keeps its own
// copy of tags, valid bits, fifo pointers and traffic counters to predict each
// result, and checks every result field by field across several geometries,
// prefetch settings and idling patterns on both channels
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_prefetch_core_tb;
    import scpf_pkg::*;

    localparam int  MAX_SETS     = 256;
    localparam int  MAX_WAYS     = 8;
    localparam int  SET_LOG2_MAX = $clog2(MAX_SETS);
    localparam int  CLK_HALF_NS  = 4;
    localparam int  TIMEOUT_NS   = 8_000_000;
    localparam int  TAIL_CYCLES  = 64;
    localparam int  PRINT_LIMIT  = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // shadow of the cache contents and counters
    logic [ADDR_BITS-1:0] tag_mem [0:MAX_SETS*MAX_WAYS-1];
    bit                   line_valid [0:MAX_SETS*MAX_WAYS-1];
    int unsigned          fifo_ptr [0:MAX_SETS-1];
    logic [CNT_W-1:0]     hits_total;
    logic [CNT_W-1:0]     misses_total;
    logic [CNT_W-1:0]     reads_total;
    logic [CNT_W-1:0]     writes_total;

    logic [3:0]           cfg_set_log2;
    logic [3:0]           cfg_blk_log2;
    logic [3:0]           cfg_ways;
    logic                 cfg_prefetch;

    t_out_item            outcome_queue [$];
    int                   mismatch_count;
    int                   sender_idle_pct;
    int                   stall_pct;
    int                   hold_off_cycles;

    set_assoc_cache_fifo_prefetch_core #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("set_assoc_cache_fifo_prefetch_core_tb failed");
        $finish;
    end

    function automatic int unsigned eff_set_log2();
        return (cfg_set_log2 > SET_LOG2_MAX) ? SET_LOG2_MAX : cfg_set_log2;
    endfunction

    function automatic int unsigned eff_way_count();
        if (cfg_ways == 0)
            return 1;
        return (cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways;
    endfunction

    function automatic logic [ADDR_BITS-1:0] random_address();
        return {$urandom, $urandom};
    endfunction

    // returns 1 when the block is present, otherwise fills it at the fifo pointer
    function automatic bit probe_and_fill(logic [ADDR_BITS-1:0] addr);
        int unsigned          slog;
        int unsigned          ways;
        int unsigned          set_idx;
        int unsigned          base;
        int unsigned          w;
        logic [ADDR_BITS-1:0] blk;
        logic [ADDR_BITS-1:0] tag;
        slog    = eff_set_log2();
        ways    = eff_way_count();
        blk     = addr >> cfg_blk_log2;
        set_idx = blk & ((48'd1 << slog) - 48'd1);
        tag     = blk >> slog;
        base    = set_idx * MAX_WAYS;
        for (w = 0; w < ways; w++) begin
            if (line_valid[base+w] && tag_mem[base+w] == tag)
                return 1'b1;
        end
        w = fifo_ptr[set_idx];
        // pointer left beyond the ways after a reconfiguration
        if (w >= ways)
            w = 0;
        tag_mem[base+w]    = tag;
        line_valid[base+w] = 1'b1;
        w++;
        if (w >= ways)
            w = 0;
        fifo_ptr[set_idx] = w;
        return 1'b0;
    endfunction

    function automatic t_out_item predict_outcome(t_in_item acc);
        t_out_item            res;
        logic [1:0]           reads;
        bit                   found;
        logic [ADDR_BITS-1:0] next_blk;
        found = probe_and_fill(acc.address);
        reads = 2'd0;
        if (found) begin
            hits_total++;
        end else begin
            misses_total++;
            reads = 2'd1;
            if (cfg_prefetch) begin
                // wraps within the address width
                next_blk = acc.address + (48'd1 << cfg_blk_log2);
                if (!probe_and_fill(next_blk))
                    reads = 2'd2;
            end
        end
        reads_total += reads;
        if (acc.opcode == OP_WRITE)
            writes_total++;
        res.hit          = found;
        res.reads_caused = reads;
        res.write_caused = (acc.opcode == OP_WRITE);
        res.total_hits   = hits_total;
        res.total_misses = misses_total;
        res.total_reads  = reads_total;
        res.total_writes = writes_total;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (outcome_queue.size() == 0) begin
                report_mismatch("unexpected result", o_out_data.total_misses, 64'd0);
            end else begin
                want = outcome_queue.pop_front();
                if (o_out_data.hit !== want.hit)
                    report_mismatch("hit", o_out_data.hit, want.hit);
                if (o_out_data.reads_caused !== want.reads_caused)
                    report_mismatch("reads_caused", o_out_data.reads_caused, want.reads_caused);
                if (o_out_data.write_caused !== want.write_caused)
                    report_mismatch("write_caused", o_out_data.write_caused, want.write_caused);
                if (o_out_data.total_hits !== want.total_hits)
                    report_mismatch("total_hits", o_out_data.total_hits, want.total_hits);
                if (o_out_data.total_misses !== want.total_misses)
                    report_mismatch("total_misses", o_out_data.total_misses, want.total_misses);
                if (o_out_data.total_reads !== want.total_reads)
                    report_mismatch("total_reads", o_out_data.total_reads, want.total_reads);
                if (o_out_data.total_writes !== want.total_writes)
                    report_mismatch("total_writes", o_out_data.total_writes, want.total_writes);
            end
        end
    end

    // result-side stall, with an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_off_cycles--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_access(input logic op, input logic [ADDR_BITS-1:0] addr);
        t_in_item acc;
        acc.opcode  = op;
        acc.address = addr;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= acc;
        do @(posedge i_clk); while (o_in_stall);
        outcome_queue.push_back(predict_outcome(acc));
    endtask

    task automatic wait_outcomes_drained();
        i_in_valid <= 1'b0;
        while (outcome_queue.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        logic [31:0] word;
        word      = $urandom;
        word[3:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SET_COUNT_LOG2:  cfg_set_log2 = word[3:0];
            REG_BLOCK_SIZE_LOG2: cfg_blk_log2 = word[3:0];
            REG_WAYS_IN_USE:     cfg_ways     = word[3:0];
            REG_PREFETCH_ENABLE: cfg_prefetch = word[0];
            default: ;
        endcase
    endtask

    // reconfigure only once every outstanding transfer has come back
    task automatic set_geometry(input logic [3:0] sets_log2, input logic [3:0] blk_log2,
                                input logic [3:0] ways, input logic prefetch);
        wait_outcomes_drained();
        write_reg(REG_SET_COUNT_LOG2, sets_log2);
        write_reg(REG_BLOCK_SIZE_LOG2, blk_log2);
        write_reg(REG_WAYS_IN_USE, ways);
        write_reg(REG_PREFETCH_ENABLE, {3'b000, prefetch});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct = sender_pct;
        stall_pct       = receiver_pct;
    endtask

    task automatic test_reset_geometry();
        set_idling(0, 0);
        send_access(OP_READ, 48'h0);
        send_access(OP_READ, 48'hF);
        send_access(OP_WRITE, 48'hFFFF_FFFF_FFFF);
        send_access(OP_WRITE, 48'hFFFF_FFFF_FFF0);
        send_access(OP_READ, 48'h0);
        send_access(OP_WRITE, 48'h0000_0000_0010);
    endtask

    task automatic test_special_geometry();
        int k;
        // set count beyond the store, zero ways, one-byte blocks, prefetch past the top
        set_geometry(4'd15, 4'd0, 4'd0, 1'b1);
        send_access(OP_READ, 48'hFFFF_FFFF_FFFF);
        send_access(OP_READ, 48'h0);
        send_access(OP_WRITE, 48'h8000_0000_0001);
        // too many ways, largest blocks, one set: walk the fifo pointer up
        set_geometry(4'd0, 4'd15, 4'd15, 1'b0);
        for (k = 1; k <= 6; k++)
            send_access(k[0], 48'(k) << 15);
        // fewer ways than the pointer now holds
        set_geometry(4'd0, 4'd15, 4'd2, 1'b0);
        send_access(OP_READ, 48'd7 << 15);
        send_access(OP_READ, 48'd1 << 15);
        send_access(OP_WRITE, 48'd7 << 15);
        // largest legal geometry, next block wraps around zero
        set_geometry(4'd8, 4'd12, 4'd8, 1'b1);
        send_access(OP_WRITE, 48'hFFFF_FFFF_F000);
        send_access(OP_READ, 48'h0000_0000_0ABC);
    endtask

    task automatic run_random_traffic(input int n_items);
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] stream;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] offset_mask;
        int unsigned          span;
        int unsigned          pick;
        int                   i;
        base        = random_address();
        stream      = random_address();
        offset_mask = (48'd1 << cfg_blk_log2) - 48'd1;
        span        = ((1 << eff_set_log2()) * eff_way_count() * 3) / 2 + 1;
        for (i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // reuse inside a working set a little larger than the cache
                addr = base + (48'($urandom_range(0, span - 1)) << cfg_blk_log2)
                       + (random_address() & offset_mask);
            end else if (pick < 80) begin
                stream = stream + (48'd1 << cfg_blk_log2);
                addr   = stream | (random_address() & offset_mask);
            end else begin
                addr = random_address();
            end
            send_access($urandom_range(0, 1), addr);
        end
    endtask

    task automatic test_random_settings();
        logic [3:0] sets_tab [0:7] = '{4'd0, 4'd8, 4'd3, 4'd2, 4'd15, 4'd5, 4'd1, 4'd6};
        logic [3:0] blk_tab  [0:7] = '{4'd0, 4'd12, 4'd4, 4'd6, 4'd15, 4'd2, 4'd3, 4'd8};
        logic [3:0] ways_tab [0:7] = '{4'd1, 4'd8, 4'd4, 4'd2, 4'd15, 4'd0, 4'd3, 4'd7};
        logic       pf_tab   [0:7] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
        int         ph;
        for (ph = 0; ph < 8; ph++) begin
            set_geometry(sets_tab[ph], blk_tab[ph], ways_tab[ph], pf_tab[ph]);
            case (ph % 4)
                0: set_idling(0, 0);
                1: set_idling(49, 0);
                2: set_idling(0, 49);
                default: set_idling(32, 32);
            endcase
            run_random_traffic(150);
        end
    endtask

    task automatic test_backpressure();
        set_geometry(4'd2, 4'd5, 4'd4, 1'b1);
        set_idling(0, 0);
        // long receiver hold-off while transfers keep being offered
        hold_off_cycles = 400;
        run_random_traffic(30);
        // sender waits for every result before going on
        wait_outcomes_drained();
        set_idling(20, 20);
        run_random_traffic(10);
    endtask

    initial begin
        int k;
        for (k = 0; k < MAX_SETS * MAX_WAYS; k++)
            line_valid[k] = 1'b0;
        for (k = 0; k < MAX_SETS; k++)
            fifo_ptr[k] = 0;
        hits_total      = '0;
        misses_total    = '0;
        reads_total     = '0;
        writes_total    = '0;
        cfg_set_log2    = 4'd0;
        cfg_blk_log2    = 4'd4;
        cfg_ways        = 4'd1;
        cfg_prefetch    = 1'b0;
        mismatch_count  = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_off_cycles = 0;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // tag store clearing pass after reset
        do @(posedge i_clk); while (o_in_stall);

        test_reset_geometry();
        test_special_geometry();
        test_random_settings();
        test_backpressure();

        wait_outcomes_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (outcome_queue.size() != 0)
            report_mismatch("results left over", outcome_queue.size(), 64'd0);
        if (mismatch_count == 0) begin
            $display("set_assoc_cache_fifo_prefetch_core_tb passed");
        end else begin
            $display("set_assoc_cache_fifo_prefetch_core_tb failed");
        end
        $finish;
    end

endmodule
